@@ hw/rtl/dnfr_pkg.sv @@
`default_nettype none

package dnfr_pkg;

    // Configuration register indexes.
    localparam logic CFG_TOTAL_WIDTH = 1'b0;
    localparam logic CFG_ROUND_MODE  = 1'b1;

    // Rounding modes. Codes five to seven act as toward zero.
    typedef enum logic [2:0] {
        RM_NEAR_EVEN = 3'd0,
        RM_NEAR_AWAY = 3'd1,
        RM_TO_ZERO   = 3'd2,
        RM_TO_POS    = 3'd3,
        RM_TO_NEG    = 3'd4
    } t_round_mode;

    // Reset value and clamping bounds of the total width register.
    localparam logic [5:0] TOTAL_WIDTH_RESET = 6'd16;
    localparam logic [5:0] TOTAL_WIDTH_MIN   = 6'd10;
    localparam logic [5:0] TOTAL_WIDTH_MAX   = 6'd32;

    // Biased binary64 exponent thresholds.
    localparam logic [10:0] EXP_MAX       = 11'h7FF;
    localparam logic [10:0] EXP_TINY      = 11'd873;   // unbiased -150
    localparam logic [10:0] EXP_HUGE      = 11'd1151;  // unbiased 128
    localparam logic [10:0] EXP_SUBN      = 11'd897;   // unbiased -126
    localparam logic [10:0] EXP_NORM_OFS  = 11'd896;   // rebias to 127

    // Narrow exponent of the largest finite value.
    localparam logic [7:0]  EXP8_MAX_FIN  = 8'd254;
    localparam logic [7:0]  EXP8_INF      = 8'hFF;

    // Decoded operand, aligned so that bit 62 is the top exponent bit of a
    // binary32 magnitude shifted up by 32.
    typedef struct packed {
        logic        sign;
        logic        special;
        logic [31:0] special_val;
        logic [62:0] ext;
        logic        sticky;
    } t_dec;

    // Operand after the rounding position has been applied.
    typedef struct packed {
        logic        sign;
        logic        special;
        logic [31:0] special_val;
        logic [30:0] trunc;
        logic        rbit;
        logic        last;
        logic        sticky;
    } t_rnd;

endpackage

`default_nettype wire

@@ hw/rtl/dnfr_decode.sv @@
`default_nettype none

module dnfr_decode (
    input  wire logic [63:0]    i_value_bits,
    input  wire logic           i_sticky_in,
    output dnfr_pkg::t_dec      o_dec
);
    import dnfr_pkg::*;

    // Classify the operand and align its significand into the wide field.
    always_comb begin
        logic        sign;
        logic [10:0] expf;
        logic [51:0] frac;
        logic [10:0] sub_amt;
        logic [10:0] exp_norm;
        sign     = i_value_bits[63];
        expf     = i_value_bits[62:52];
        frac     = i_value_bits[51:0];
        sub_amt  = EXP_SUBN - expf;
        exp_norm = expf - EXP_NORM_OFS;

        o_dec             = '0;
        o_dec.sign        = sign;
        o_dec.sticky      = i_sticky_in | (|frac[27:0]);

        priority if (expf == EXP_MAX) begin
            // Infinity and NaN pass as full binary32 patterns.
            o_dec.special = 1'b1;
            if (frac == 52'd0) begin
                o_dec.special_val = {sign, EXP8_INF, 23'd0};
            end else begin
                o_dec.special_val = {sign, EXP8_INF, 1'b1, frac[50:29]};
            end
        end else if (i_value_bits[62:0] == 63'd0) begin
            // Signed zero is exact.
            o_dec.special     = 1'b1;
            o_dec.special_val = {sign, 31'd0};
        end else if (expf < EXP_TINY) begin
            // Far below the least subnormal: zero with sticky set.
            o_dec.ext    = '0;
            o_dec.sticky = 1'b1;
        end else if (expf >= EXP_HUGE) begin
            // Beyond range: max finite with round and sticky bits set.
            o_dec.ext    = {EXP8_MAX_FIN, {55{1'b1}}};
            o_dec.sticky = 1'b1;
        end else if (expf < EXP_SUBN) begin
            // Subnormal result: shift the significand with its hidden bit.
            o_dec.ext = {7'd0, 1'b1, frac[51:28], 31'd0} >> sub_amt[4:0];
        end else begin
            o_dec.ext = {exp_norm[7:0], frac[51:28], 31'd0};
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/double_to_narrow_float_rounder_top.sv @@
`default_nettype none

// Rounds an IEEE binary64 pattern, with a sticky flag for bits lying below
// it, to a narrow float of total_width bits (sign, eight exponent bits, the
// rest fraction) under one of five rounding modes, with gradual underflow.
// The result is left-aligned in a binary32 word; infinity and NaN come out
// as full binary32 patterns with NaN made quiet. A new transaction is
// accepted every clock cycle while the output side does not stall. The
// accepting edge loads the first stage, and the result then passes
// through the rounding-position register to the result register that
// drives the output. There are three register stages: decode and align,
// rounding-position mask, and the rounding increment. A stall on the
// output fills empty stages first and then holds the input ready low.
// Configuration writes take effect at once and are to be made only while
// no transaction is in flight.

module double_to_narrow_float_rounder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [5:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_value_bits,
    input  wire logic        i_sticky_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_result_bits
);
    import dnfr_pkg::*;

    logic [5:0]  r_total_width;
    logic [2:0]  r_round_mode;
    logic [4:0]  w_k;

    logic        r_v1, r_v2, r_v3;
    logic        w_rdy1, w_rdy2, w_rdy3;
    t_dec        w_dec;
    t_dec        r_dec;
    t_rnd        n_rnd;
    t_rnd        r_rnd;
    logic [31:0] n_result;
    logic [31:0] r_result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_width <= TOTAL_WIDTH_RESET;
            r_round_mode  <= RM_NEAR_EVEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOTAL_WIDTH: r_total_width <= i_cfg_wdata;
                CFG_ROUND_MODE:  r_round_mode  <= i_cfg_wdata[2:0];
                default:         r_round_mode  <= r_round_mode;
            endcase
        end
    end

    // Number of unused low bits in the left-aligned 32-bit word.
    always_comb begin
        logic [5:0] diff;
        diff = TOTAL_WIDTH_MAX - r_total_width;
        priority if (r_total_width < TOTAL_WIDTH_MIN) begin
            w_k = 5'd22;
        end else if (r_total_width > TOTAL_WIDTH_MAX) begin
            w_k = 5'd0;
        end else begin
            w_k = diff[4:0];
        end
    end

    // Stage flow control: a stage loads when it is empty or moves on.
    assign w_rdy3     = !r_v3 || i_out_ready;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage one: decode and align.
    dnfr_decode u_decode (
        .i_value_bits (i_value_bits),
        .i_sticky_in  (i_sticky_in),
        .o_dec        (w_dec)
    );

    // Stage two: split the aligned field at the rounding position.
    always_comb begin
        logic [30:0] low_mask;
        logic [30:0] top;
        logic [22:0] mid;
        top      = r_dec.ext[62:32];
        mid      = r_dec.ext[53:31];
        low_mask = (31'd1 << w_k) - 31'd1;

        n_rnd             = '0;
        n_rnd.sign        = r_dec.sign;
        n_rnd.special     = r_dec.special;
        n_rnd.special_val = r_dec.special_val;
        n_rnd.trunc       = top & ~low_mask;
        n_rnd.rbit        = mid[w_k];
        n_rnd.last        = top[w_k];
        n_rnd.sticky      = r_dec.sticky | (|r_dec.ext[30:0]) | (|(mid & low_mask[22:0]));
    end

    // Stage three: decide the increment and add it at the rounding position.
    always_comb begin
        logic        up;
        logic [30:0] sum;
        unique case (r_round_mode)
            RM_NEAR_EVEN: up = r_rnd.rbit & (r_rnd.last | r_rnd.sticky);
            RM_NEAR_AWAY: up = r_rnd.rbit;
            RM_TO_POS:    up = !r_rnd.sign & (r_rnd.rbit | r_rnd.sticky);
            RM_TO_NEG:    up = r_rnd.sign & (r_rnd.rbit | r_rnd.sticky);
            default:      up = 1'b0;
        endcase
        sum = r_rnd.trunc + (31'(up) << w_k);
        if (r_rnd.special) begin
            n_result = r_rnd.special_val;
        end else begin
            n_result = {r_rnd.sign, sum};
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_in_valid) begin
            r_dec <= w_dec;
        end
        if (w_rdy2 && r_v1) begin
            r_rnd <= n_rnd;
        end
        if (w_rdy3 && r_v2) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_v3;
    assign o_result_bits = r_result;

endmodule

`default_nettype wire

@@ hw/rtl/dnfr_checker.sv @@
`default_nettype none

module dnfr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_result_bits
);

    // A stalled result stays put until the transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_bits))
        else $error("output transaction dropped or changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // With no result waiting, every stage can move, so input must be ready.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while pipeline output is empty");

    // A NaN result is always quiet; a rounding carry only ever gives infinity.
    a_nan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_bits[30:23] == 8'hFF) && (o_result_bits[22:0] != 23'd0)
        |-> o_result_bits[22])
        else $error("signaling NaN or malformed infinity on output");

endmodule

bind double_to_narrow_float_rounder_top dnfr_checker u_dnfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_bits (o_result_bits)
);

`default_nettype wire
